// ----- sv/iss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

   // Number of slots in the set store.
   localparam int CAPACITY = 16;

   // Slot index width; at least one bit so that a single-slot store still works.
   localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   // Internal element counter must hold CAPACITY itself.
   localparam int CNT_W   = $clog2(CAPACITY + 1);

   // Fixed field widths of the request and response.
   localparam int OP_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);

   // Operation codes. The unused code behaves as a query.
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE    = 2'd0,
      STAT_PRESENT = 2'd1,
      STAT_ABSENT  = 2'd2,
      STAT_FULL    = 2'd3
   } iss_status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_DRAIN = 2'd2,
      ST_DONE  = 2'd3
   } iss_state_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      logic              load;     // transaction accepted this cycle
      logic              rd_en;    // slot read issued this cycle
      logic [SLOT_W-1:0] rd_addr;
      logic              cmp_en;   // read data of cmp_idx is on the RAM output
      logic [SLOT_W-1:0] cmp_idx;
      logic              finish;   // scan complete, commit and respond
   } iss_ctl_type;

endpackage

`default_nettype wire

// ----- sv/integer_set_store_core.sv -----
// Set of up to CAPACITY distinct 32-bit integers. Raise start with req_op (add, remove or
// query) and req_value while busy is low; the transaction is taken at that clock edge and
// busy stays high until it is finished. Every transaction returns exactly one response,
// shown on rsp_status, rsp_present and rsp_count for one cycle while rsp_strobe is high;
// the receiver cannot stall it, so it must capture the response in that cycle. A
// transaction passes through the accept, the scan of every slot, a drain state and a
// commit state before its response appears, and a new one can be started in the cycle
// its predecessor's response appears. The scan is set by the single read port of the
// slot value memory: every slot is read and compared once, one slot per cycle, and the
// drain state waits for the registered read of the last slot. Valid marks live in
// flip-flops and are cleared at reset, so the block is usable right after reset with no
// clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module integer_set_store_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic [iss_pkg::OP_W-1:0]            req_op,
   input  wire logic signed [iss_pkg::VALUE_W-1:0]  req_value,
   output      logic                                rsp_strobe,
   output      logic [iss_pkg::STATUS_W-1:0]        rsp_status,
   output      logic                                rsp_present,
   output      logic [iss_pkg::COUNT_W-1:0]         rsp_count
);

   import iss_pkg::*;

   iss_ctl_type ctl;

   // Transaction held for the duration of the scan.
   logic [OP_W-1:0]    op_ff, op_in;
   logic [VALUE_W-1:0] value_ff, value_in;

   // Scan results: slot holding the value and lowest free slot.
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] hit_idx_ff, hit_idx_in;
   logic              free_ff, free_in;
   logic [SLOT_W-1:0] free_idx_ff, free_idx_in;

   // Set state besides the slot values.
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   // Response register.
   logic                 rsp_strobe_ff, rsp_strobe_in;
   iss_status_type       rsp_status_ff, rsp_status_in;
   logic                 rsp_present_ff, rsp_present_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [VALUE_W-1:0] rd_data;
   logic               slot_match;
   logic               slot_free;
   logic               wr_en;

   iss_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctl   (ctl)
   );

   // Slot values; written only when an add commits, so an unwritten slot is
   // never compared while marked valid.
   iss_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (value_ff),
      .rd_en   (ctl.rd_en),
      .rd_addr (ctl.rd_addr),
      .rd_data (rd_data)
   );

   // The valid mark is read at the compare stage, matching the registered RAM output.
   assign slot_match = ctl.cmp_en && valid_ff[ctl.cmp_idx] && (rd_data == value_ff);
   assign slot_free  = ctl.cmp_en && !valid_ff[ctl.cmp_idx];

   always_comb begin
      op_in       = ctl.load ? req_op : op_ff;
      value_in    = ctl.load ? VALUE_W'(req_value) : value_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (ctl.load) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else begin
         if (slot_match && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = ctl.cmp_idx;
         end
         // The scan runs upward, so the first free slot seen is the lowest one.
         if (slot_free && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = ctl.cmp_idx;
         end
      end
   end

   // Commit and response, evaluated in the finishing cycle.
   always_comb begin
      wr_en          = 1'b0;
      valid_in       = valid_ff;
      count_in       = count_ff;
      rsp_status_in  = STAT_DONE;
      rsp_present_in = 1'b0;
      unique case (op_ff)
         OP_ADD: begin
            if (hit_ff) begin
               rsp_status_in  = STAT_PRESENT;
               rsp_present_in = 1'b1;
            end else if (!free_ff) begin
               rsp_status_in  = STAT_FULL;
               rsp_present_in = 1'b0;
            end else begin
               wr_en          = ctl.finish;
               rsp_status_in  = STAT_DONE;
               rsp_present_in = 1'b1;
               if (ctl.finish) begin
                  valid_in[free_idx_ff] = 1'b1;
                  count_in              = count_ff + CNT_W'(1);
               end
            end
         end
         OP_REMOVE: begin
            rsp_present_in = 1'b0;
            if (hit_ff) begin
               rsp_status_in = STAT_DONE;
               if (ctl.finish) begin
                  valid_in[hit_idx_ff] = 1'b0;
                  count_in             = count_ff - CNT_W'(1);
               end
            end else begin
               rsp_status_in = STAT_ABSENT;
            end
         end
         default: begin
            // Query, and the unused code which behaves as one.
            rsp_status_in  = hit_ff ? STAT_DONE : STAT_ABSENT;
            rsp_present_in = hit_ff;
         end
      endcase
      rsp_strobe_in = ctl.finish;
      rsp_count_in  = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         valid_ff      <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         hit_ff        <= hit_in;
         free_ff       <= free_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff       <= op_in;
      value_ff    <= value_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      if (ctl.finish) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_present_ff <= rsp_present_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_present = rsp_present_ff;
   assign rsp_count   = rsp_count_ff;

   // The element count always agrees with the number of valid marks.
   assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("element count out of step with valid marks");

   // Values are distinct, so a scan never finds a second matching slot.
   assert property (@(posedge clock) disable iff (reset)
      slot_match |-> !hit_ff)
      else $error("value found in two slots");

   // A full report only comes when every slot is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_status_ff == STAT_FULL)) |-> (count_ff == CNT_FULL))
      else $error("store reported full with a free slot");

endmodule

`default_nettype wire

// ----- sv/iss_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module iss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/iss_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module iss_seq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   output      iss_pkg::iss_ctl_type ctl
);

   import iss_pkg::*;

   iss_state_type     state_ff, state_in;
   logic [SLOT_W-1:0] addr_ff, addr_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0] cmp_idx_ff, cmp_idx_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (addr_ff == SLOT_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Scan address and compare pipeline.
   always_comb begin
      addr_in    = (state_ff == ST_SCAN) ? addr_ff + SLOT_W'(1) : '0;
      cmp_vld_in = (state_ff == ST_SCAN);
      cmp_idx_in = addr_ff;
   end

   // Outputs.
   always_comb begin
      busy        = (state_ff != ST_IDLE);
      ctl.load    = start && (state_ff == ST_IDLE);
      ctl.rd_en   = (state_ff == ST_SCAN);
      ctl.rd_addr = addr_ff;
      ctl.cmp_en  = cmp_vld_ff;
      ctl.cmp_idx = cmp_idx_ff;
      ctl.finish  = (state_ff == ST_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         addr_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      cmp_idx_ff <= cmp_idx_in;
   end

   // The block only goes idle after committing a transaction.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(state_ff == ST_DONE))
      else $error("busy dropped without finishing a transaction");

endmodule

`default_nettype wire
